// ----- design/fixed_frame_word_receiver_core_macros.svh -----
// Assertion macros for the frame word receiver
`ifndef FIXED_FRAME_WORD_RECEIVER_CORE_MACROS_SVH
`define FIXED_FRAME_WORD_RECEIVER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define FFWR_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");

// Implication whose consequent is checked in the following cycle
`define FFWR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");

`endif

// ----- design/ffwr_pkg.sv -----
package ffwr_pkg;
  localparam int unsigned FrameLen = 19;
  localparam logic [7:0] HeaderByte = 8'hA5;
  localparam logic [7:0] TrailerByte = 8'h5A;
  localparam logic [31:0] LowReset = 32'h40C00000;
  localparam logic [31:0] HighReset = 32'h41A00000;
  localparam int unsigned QueueDepth = 2;
  localparam logic RegLow = 1'b0;
  localparam logic RegHigh = 1'b1;

  // Four payload words of one good frame
  typedef struct packed {
    logic [31:0] gain;
    logic [31:0] speed;
    logic [31:0] tword;
    logic [31:0] angle;
  } frame_words_t;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F800000;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] x);
    return x[31] ? ~x : (x | 32'h80000000);
  endfunction

  // IEEE single a > b on raw bits
  function automatic logic float_greater(input logic [31:0] a, input logic [31:0] b);
    logic nan_any;
    logic zeros;
    nan_any = is_nan(a) | is_nan(b);
    zeros = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    return !nan_any && !zeros && (order_key(a) > order_key(b));
  endfunction
endpackage

// ----- design/ffwr_framer.sv -----
// Front part: hunt for header, shift bytes in, flag frames with good trailer
module ffwr_framer
  import ffwr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   rx_byte,
  output logic         frame_valid,
  output frame_words_t frame
);
  localparam int unsigned CountW = $clog2(FrameLen + 1);

  logic [CountW-1:0] byte_count;
  logic [7:0] shift [FrameLen-1];

  // Count bytes of the current frame; zero means hunting
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (take) begin
      if (byte_count == '0) begin
        if (rx_byte == HeaderByte) byte_count <= CountW'(1);
      end else if (byte_count == CountW'(FrameLen - 1)) begin
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + CountW'(1);
      end
    end
  end

  // Shift data bytes in; oldest byte ends at index 0
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < FrameLen - 2; i++) shift[i] <= shift[i+1];
      shift[FrameLen-2] <= rx_byte;
    end
  end

  // On the last byte, shift[0] is header and shift[1..17] are bytes 1..17
  assign frame_valid = take && (byte_count == CountW'(FrameLen - 1))
                       && (rx_byte == TrailerByte);
  assign frame.gain  = {shift[4], shift[3], shift[2], shift[1]};
  assign frame.speed = {shift[8], shift[7], shift[6], shift[5]};
  assign frame.tword = {shift[12], shift[11], shift[10], shift[9]};
  assign frame.angle = {shift[16], shift[15], shift[14], shift[13]};

  logic unused_tail;
  assign unused_tail = ^{shift[0], shift[17]};
endmodule

// ----- design/ffwr_queue.sv -----
// Short queue between framer and clamp stage
module ffwr_queue
  import ffwr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  frame_words_t wdata,
  output logic         nonempty,
  input  logic         rd,
  output frame_words_t rdata
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  frame_words_t slot [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0] count;

  // Advance pointers on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + PtrW'(1);
      if (rd) rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + PtrW'(1);
      count <= count + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot[wptr] <= wdata;
  end

  assign nonempty = count != '0;
  assign rdata = slot[rptr];
endmodule

// ----- design/ffwr_clamp.sv -----
// Back part: clamp third word and hold the result register
module ffwr_clamp
  import ffwr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  frame_words_t in_words,
  output logic         in_take,
  input  logic [31:0]  low_limit,
  input  logic [31:0]  high_limit,
  output logic         out_valid,
  input  logic         out_take,
  output frame_words_t out_words
);
  logic [31:0] t_next;

  // Clamp: high test first, then low
  always_comb begin
    t_next = in_words.tword;
    if (float_greater(in_words.tword, high_limit)) t_next = high_limit;
    else if (float_greater(low_limit, in_words.tword)) t_next = low_limit;
  end

  assign in_take = in_valid && (!out_valid || out_take);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_take) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_words <= {in_words.gain, in_words.speed, t_next, in_words.angle};
    end
  end
endmodule

// ----- design/fixed_frame_word_receiver_core.sv -----
// Accepts one byte per cycle; full only while the result path backs up.
// A good frame is queued on its trailer beat, then registered for output.
// Throughput: 1 byte per cycle while not full.
// Reset: hunting for header, queue and result empty, limits 6.0 and 20.0.
module fixed_frame_word_receiver_core
  import ffwr_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] gain_word,
  output logic [31:0] speed_word,
  output logic [31:0] time_word,
  output logic [31:0] angle_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] low_limit, high_limit;
  logic take, frame_valid, q_nonempty, q_rd, out_valid;
  logic [$clog2(Depth+1)-1:0] pending;
  frame_words_t frame, q_words, out_words;

  // Config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit <= LowReset;
      high_limit <= HighReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegLow) low_limit <= cfg_data;
      if (cfg_index == RegHigh) high_limit <= cfg_data;
    end
  end

  // Hold input while queue could overflow
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + $bits(pending)'(frame_valid) - $bits(pending)'(q_rd);
  end
  assign full = pending == $bits(pending)'(Depth);
  assign take = push && !full;

  ffwr_framer u_framer (
    .clk, .rst, .take, .rx_byte, .frame_valid, .frame
  );

  ffwr_queue #(.Depth(Depth)) u_queue (
    .clk, .rst, .wr(frame_valid), .wdata(frame), .nonempty(q_nonempty),
    .rd(q_rd), .rdata(q_words)
  );

  ffwr_clamp u_clamp (
    .clk, .rst, .in_valid(q_nonempty), .in_words(q_words), .in_take(q_rd),
    .low_limit, .high_limit, .out_valid, .out_take(pop && out_valid),
    .out_words
  );

  assign empty = !out_valid;
  assign gain_word = out_words.gain;
  assign speed_word = out_words.speed;
  assign time_word = out_words.tword;
  assign angle_word = out_words.angle;
endmodule

// ----- design/ffwr_checker.sv -----
`include "fixed_frame_word_receiver_core_macros.svh"
// Port-level checks on the receiver
module ffwr_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] time_word
);
  // Held result stays until popped
  `FFWR_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(time_word))
  // An empty output stays empty unless an input beat is taken now or was taken at the last sampled edge
  `FFWR_ASSERT_NEXT(a_no_invent, clk, rst, empty && !(push && !full) && !$past(push && !full), empty)
  // Full only when a result waits
  `FFWR_ASSERT_IMP(a_full_backed, clk, rst, full, !empty)
endmodule

bind fixed_frame_word_receiver_core ffwr_checker u_ffwr_checker (
  .clk, .rst, .push, .full, .empty, .pop, .time_word
);

// ----- verif/fixed_frame_word_receiver_core_tb.sv -----
module fixed_frame_word_receiver_core_tb;
  import ffwr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Frame predictor and store of expected payload words
  class frame_scoreboard;
    logic [31:0] low_limit;
    logic [31:0] high_limit;
    int unsigned held;
    logic [7:0] frame_bytes [FrameLen];
    frame_words_t expected_words [$];
    int unsigned errors;

    function new();
      low_limit = LowReset;
      high_limit = HighReset;
      held = 0;
      errors = 0;
    endfunction

    function void set_limit(logic idx, logic [31:0] value);
      if (idx == RegLow) begin
        low_limit = value;
      end else begin
        high_limit = value;
      end
    endfunction

    function bit nan_bits(logic [31:0] x);
      return x[30:0] > 31'h7F800000;
    endfunction

    // IEEE single a > b, zeros equal, NaN never ordered
    function bit above(logic [31:0] a, logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      if (nan_bits(a) || nan_bits(b)) return 0;
      if (a[30:0] == 0 && b[30:0] == 0) return 0;
      ka = a[31] ? ~a : {1'b1, a[30:0]};
      kb = b[31] ? ~b : {1'b1, b[30:0]};
      return ka > kb;
    endfunction

    function logic [31:0] word_from(int unsigned first);
      return {frame_bytes[first + 3], frame_bytes[first + 2],
              frame_bytes[first + 1], frame_bytes[first]};
    endfunction

    // Advance the frame state by one accepted byte beat
    function void note_byte(logic [7:0] b);
      frame_words_t w;
      if (held == 0) begin
        if (b == HeaderByte) begin
          frame_bytes[0] = b;
          held = 1;
        end
        return;
      end
      frame_bytes[held] = b;
      held++;
      if (held < FrameLen) return;
      held = 0;
      if (frame_bytes[FrameLen - 1] != TrailerByte) return;
      w.gain = word_from(1);
      w.speed = word_from(5);
      w.tword = word_from(9);
      w.angle = word_from(13);
      if (above(w.tword, high_limit)) begin
        w.tword = high_limit;
      end else if (above(low_limit, w.tword)) begin
        w.tword = low_limit;
      end
      expected_words.push_back(w);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(frame_words_t act);
      frame_words_t e;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, act);
        return;
      end
      e = expected_words.pop_front();
      check_field("gain_word", e.gain, act.gain);
      check_field("speed_word", e.speed, act.speed);
      check_field("time_word", e.tword, act.tword);
      check_field("angle_word", e.angle, act.angle);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full;
  logic [7:0] rx_byte = 0;
  logic empty;
  logic pop = 0;
  logic [31:0] gain_word, speed_word, time_word, angle_word;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  frame_scoreboard sb = new();
  bit send_burst = 0;
  bit pop_burst = 0;

  fixed_frame_word_receiver_core dut (.*);

  always #1 clk = ~clk;

  // Drain results with random pop stalls
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop = 0;
      end else if (stall > 0) begin
        pop = 0;
        stall--;
      end else begin
        pop = 1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_result({gain_word, speed_word, time_word, angle_word});
        stall = pop_burst ? 0 : $urandom_range(0, 17);
      end
    end
  end

  // Send one byte beat, after a random gap unless sending a burst
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk);
      push = 0;
    end
    @(negedge clk);
    push = 1;
    rx_byte = b;
    do @(posedge clk); while (full);
    sb.note_byte(b);
  endtask

  task automatic send_frame(logic [31:0] g, logic [31:0] s, logic [31:0] t,
                            logic [31:0] a, logic [7:0] trailer);
    logic [127:0] payload;
    payload = {a, t, s, g};
    send_byte(HeaderByte);
    for (int i = 0; i < 16; i++) send_byte(payload[8 * i +: 8]);
    send_byte(8'($urandom));
    send_byte(trailer);
  endtask

  // Hold until every expected result is out and the pipeline has drained
  task automatic wait_drained();
    @(negedge clk);
    push = 0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_limit(idx, value);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: return 32'h7FC00000 | $urandom_range(0, 255);
      1: return 32'h00000000;
      2: return 32'h80000000;
      3: return 32'h7F800000;
      4: return 32'hFF800000;
      5: return sb.low_limit;
      6: return sb.high_limit;
      7: return 32'h40000000 + $urandom_range(0, 32'h02000000);
      default: return $urandom;
    endcase
  endfunction

  // Limit pairs per phase: defaults, zero and NaN, infinities, crossed, signed zeros, NaN
  logic [31:0] low_set [6] = '{LowReset, 32'h00000000, 32'hFF800000, 32'h41A00000,
                               32'h80000000, 32'hFFFFFFFF};
  logic [31:0] high_set [6] = '{HighReset, 32'hFFFFFFFF, 32'h7F800000, 32'h40C00000,
                                32'h00000000, 32'h7FFFFFFF};

  initial begin
    int unsigned r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed frames under reset limits
    send_burst = 1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(32'h0, 32'hFFFFFFFF, 32'h41000000, 32'hA5A5A5A5, TrailerByte);
    send_frame(32'hFFFFFFFF, 32'h0, 32'h7FC00001, 32'h5A5A5A5A, TrailerByte);
    send_frame(32'h1, 32'h2, 32'h42000000, 32'h3, 8'h00);
    send_frame(32'h1, 32'h2, 32'h3F800000, 32'h3, TrailerByte);
    send_frame(32'h1, 32'h2, 32'hC2000000, 32'h3, TrailerByte);
    send_burst = 0;

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_limit(RegLow, low_set[p]);
      write_limit(RegHigh, high_set[p]);
      send_frame($urandom, $urandom, 32'h80000000, $urandom, TrailerByte);
      send_frame($urandom, $urandom, 32'h7FC00000, $urandom, TrailerByte);
      for (int f = 0; f < 11; f++) begin
        send_burst = ($urandom_range(0, 3) == 0);
        pop_burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        if (r == 0) begin
          repeat ($urandom_range(1, 6)) send_byte($urandom);
        end else if (r == 1) begin
          send_frame($urandom, $urandom, pick_time(), $urandom, $urandom);
        end else begin
          send_frame($urandom, $urandom, pick_time(), $urandom, TrailerByte);
        end
      end
    end
    send_burst = 0;
    pop_burst = 0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
